FILE: rtl/trs_pkg.sv
// shared types, widths and register codes for the triangle span rasterizer
package trs_pkg;

    // fixed field widths of the input and result words
    localparam int FLD_W      = 16;
    localparam int COLOR_W    = 24;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SW_W       = 9;
    localparam int SH_W       = 7;

    localparam logic [SW_W-1:0] SW_RESET = 9'd98;
    localparam logic [SH_W-1:0] SH_RESET = 7'd50;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // parameter defaults
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_COORD_BITS = 16;

    // input word: one triangle
    typedef struct packed {
        logic signed [FLD_W-1:0] ax;
        logic signed [FLD_W-1:0] ay;
        logic signed [FLD_W-1:0] bx;
        logic signed [FLD_W-1:0] by;
        logic signed [FLD_W-1:0] cx;
        logic signed [FLD_W-1:0] cy;
        logic [COLOR_W-1:0]      fill_color;
    } t_tri;

    // result word: one span
    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   x_start;
        logic [COL_W-1:0]   x_end;
        logic [COLOR_W-1:0] span_color;
        logic               span_valid;
        logic               last;
    } t_span;

    // multiply-accumulate control
    typedef struct packed {
        logic load;
        logic first;
    } t_mac_ctl;

endpackage

FILE: rtl/trs_mac.sv
// shared multiplier with accumulator for interpolation numerators
module trs_mac
    import trs_pkg::*;
#(
    parameter int OP_W = DEF_COORD_BITS + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mac_ctl               i_ctl,
    input  logic signed [OP_W-1:0] i_a,
    input  logic signed [OP_W-1:0] i_b,
    output logic signed [2*OP_W:0] o_acc
);

    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = 2 * OP_W + 1;

    logic                     r_prod_vld;
    logic                     r_prod_first;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    // product stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld   <= 1'b0;
            r_prod_first <= 1'b0;
        end else begin
            r_prod_vld   <= i_ctl.load;
            r_prod_first <= i_ctl.first;
        end
    end

    // multiply, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_prod_vld) begin
            if (r_prod_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/trs_div.sv
// serial restoring divider, one quotient bit per cycle, truncates toward zero
module trs_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 17,
    parameter int Q_W   = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [Q_W:0]     o_quo
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_dsh;
    logic [Q_W-1:0]   r_q;
    logic             r_neg;

    logic             fits;
    logic [NUM_W-1:0] rem_sub;

    // trial subtract of the shifted divisor
    always_comb begin
        fits    = r_rem >= r_dsh;
        rem_sub = r_rem - r_dsh;
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude datapath, divisor is always positive
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_rem <= i_num[NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
            r_dsh <= NUM_W'($unsigned(i_den)) << (Q_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rem_sub;
            end
            r_q   <= {r_q[Q_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

FILE: rtl/triangle_span_rasterizer.sv
// triangle span rasterizer: row sequencer, shared multiplier and serial divider
// rows: each row that is on screen and has a live half runs two multiply and divide passes,
//   a zero-height half skips them; the last word strobes in the cycle after finishing
// operation: one triangle at a time, busy from accept to the last word; two divisions per
//   live row on one serial divider set the row time
// reset: synchronous active low, returns to idle and loads the screen size defaults
// results are strobed for one cycle each and cannot be held off by the receiver
module triangle_span_rasterizer
    import trs_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_tri                  i_tri,
    output logic                  busy,
    output logic                  o_span_stb,
    output t_span                 o_span,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int EW    = CB + 1;
    localparam int QW    = CB + 2;
    localparam int NUM_W = 2 * EW + 1;
    localparam int YW    = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_ROW0, S_ROW1, S_ROW2,
        S_MUL0, S_MUL1, S_MUL2, S_MUL3,
        S_DGO, S_DWAIT, S_CLIP0, S_CLIP1,
        S_NEXT, S_FINISH
    } t_state;

    // control and result registers
    t_state r_state, n_state;
    logic   r_out_stb, n_out_stb;
    t_span  r_out, n_out;
    t_span  r_pend, n_pend;
    logic   r_pend_vld, n_pend_vld;

    // configuration
    logic [SW_W-1:0] r_sw;
    logic [SH_W-1:0] r_sh;

    // triangle and row datapath
    logic signed [CB-1:0] r_ax, r_ay, r_bx;
    logic signed [EW-1:0] r_total, r_upper, r_seglo;
    logic signed [EW-1:0] r_dca, r_dba, r_dcb;
    logic [COLOR_W-1:0]   r_color;
    logic [YW-1:0]        r_y, r_yhi;
    logic signed [EW-1:0] r_i, r_k, r_seg;
    logic                 r_second;
    logic                 r_pass;
    logic signed [QW-1:0] r_xa, r_lo, r_hi;

    // accept-time decode
    logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic [YW-1:0]        h_eff;
    logic [SW_W-1:0]      w_eff;
    logic signed [EW-1:0] h_e;
    logic signed [QW-1:0] wm1;
    logic [YW-1:0]        ylo, yhi;
    logic                 any_row;

    // shared unit wiring
    t_mac_ctl             mac_ctl;
    logic signed [EW-1:0] mac_a, mac_b;
    logic signed [NUM_W-1:0] mac_acc;
    logic signed [CB-1:0] op_p;
    logic signed [EW-1:0] op_den, op_diff, op_k;
    logic                 div_done;
    logic signed [QW-1:0] div_quo;

    // row clipping
    logic signed [QW-1:0] x_lo, x_hi;
    logic [YW-1:0]        y_inc;
    t_span                span_new;

    // config register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SW_RESET;
            r_sh <= SH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_sw <= i_cfg_data[SW_W-1:0];
                REG_SCREEN_HEIGHT: r_sh <= i_cfg_data[SH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective screen size
    assign h_eff = (32'(r_sh) < MAX_ROWS) ? YW'(r_sh) : YW'(MAX_ROWS);
    assign w_eff = (32'(r_sw) < MAX_COLS) ? r_sw : SW_W'(MAX_COLS);
    assign h_e   = EW'(h_eff);
    assign wm1   = QW'($signed({1'b0, w_eff})) - QW'(1);

    // coordinates: low COORD_BITS of each field, sign taken from that width
    assign in_ax = CB'($unsigned(i_tri.ax));
    assign in_ay = CB'($unsigned(i_tri.ay));
    assign in_bx = CB'($unsigned(i_tri.bx));
    assign in_by = CB'($unsigned(i_tri.by));
    assign in_cx = CB'($unsigned(i_tri.cx));
    assign in_cy = CB'($unsigned(i_tri.cy));

    // visible row range
    assign ylo     = in_ay[CB-1] ? '0 : YW'(in_ay);
    assign yhi     = (EW'(in_cy) < h_e) ? YW'(in_cy) : h_eff;
    assign any_row = (in_cy > in_ay) && (EW'(in_ay) < h_e)
                     && !in_cy[CB-1] && (in_cy != '0) && (ylo < yhi);

    // operand select: long edge on the first pass, short edge on the second
    always_comb begin
        op_den  = r_pass ? r_seg : r_total;
        op_p    = (r_pass && r_second) ? r_bx : r_ax;
        op_k    = (r_pass && r_second) ? r_k : r_i;
        op_diff = !r_pass ? r_dca : (r_second ? r_dcb : r_dba);
    end

    assign mac_ctl.load  = (r_state == S_MUL0) || (r_state == S_MUL1);
    assign mac_ctl.first = (r_state == S_MUL0);
    assign mac_a = (r_state == S_MUL0) ? EW'(op_p) : op_diff;
    assign mac_b = (r_state == S_MUL0) ? op_den : op_k;

    trs_mac #(
        .OP_W (EW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    trs_div #(
        .NUM_W (NUM_W),
        .DEN_W (EW),
        .Q_W   (CB + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DGO),
        .i_num   (mac_acc),
        .i_den   (op_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // order the long-edge and short-edge x values
    assign x_lo  = (r_xa > div_quo) ? div_quo : r_xa;
    assign x_hi  = (r_xa > div_quo) ? r_xa : div_quo;
    assign y_inc = r_y + YW'(1);

    always_comb begin
        span_new            = '0;
        span_new.row        = ROW_W'(r_y);
        span_new.x_start    = COL_W'(r_lo);
        span_new.x_end      = COL_W'(r_hi);
        span_new.span_color = r_color;
        span_new.span_valid = 1'b1;
        span_new.last       = 1'b0;
    end

    // sequencer next state and result words
    always_comb begin
        n_state    = r_state;
        n_out_stb  = 1'b0;
        n_out      = r_out;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pend_vld = 1'b0;
                    n_state    = any_row ? S_ROW0 : S_FINISH;
                end
            end
            S_ROW0: n_state = S_ROW1;
            S_ROW1: n_state = S_ROW2;
            S_ROW2: n_state = (r_seg == '0) ? S_NEXT : S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_DGO;
            S_DGO:  n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) begin
                    n_state = r_pass ? S_CLIP0 : S_MUL0;
                end
            end
            S_CLIP0: n_state = S_CLIP1;
            S_CLIP1: begin
                // a new span pushes the held one out, which is then known not last
                if (r_lo <= r_hi) begin
                    if (r_pend_vld) begin
                        n_out     = r_pend;
                        n_out_stb = 1'b1;
                    end
                    n_pend     = span_new;
                    n_pend_vld = 1'b1;
                end
                n_state = S_NEXT;
            end
            S_NEXT: n_state = (y_inc < r_yhi) ? S_ROW0 : S_FINISH;
            S_FINISH: begin
                n_out_stb = 1'b1;
                if (r_pend_vld) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                end else begin
                    n_out      = '0;
                    n_out.last = 1'b1;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_stb  <= 1'b0;
            r_out      <= '0;
            r_pend     <= '0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_stb  <= n_out_stb;
            r_out      <= n_out;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
        end
    end

    // triangle and row datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_ax    <= in_ax;
                    r_ay    <= in_ay;
                    r_bx    <= in_bx;
                    r_total <= EW'(in_cy) - EW'(in_ay);
                    r_upper <= EW'(in_by) - EW'(in_ay);
                    r_seglo <= EW'(in_cy) - EW'(in_by);
                    r_dca   <= EW'(in_cx) - EW'(in_ax);
                    r_dba   <= EW'(in_bx) - EW'(in_ax);
                    r_dcb   <= EW'(in_cx) - EW'(in_bx);
                    r_color <= i_tri.fill_color;
                    r_y     <= ylo;
                    r_yhi   <= yhi;
                end
            end
            S_ROW0: begin
                r_i    <= EW'(r_y) - EW'(r_ay);
                r_pass <= 1'b0;
            end
            S_ROW1: begin
                // lower half once past the middle vertex, or when the top half is flat
                r_second <= (r_i > r_upper) || (r_upper == '0);
                r_k      <= r_i - r_upper;
                r_seg    <= ((r_i > r_upper) || (r_upper == '0)) ? r_seglo : r_upper;
            end
            S_DWAIT: begin
                if (div_done && !r_pass) begin
                    r_xa   <= div_quo;
                    r_pass <= 1'b1;
                end
            end
            S_CLIP0: begin
                r_lo <= x_lo[QW-1] ? '0 : x_lo;
                r_hi <= (x_hi > wm1) ? wm1 : x_hi;
            end
            S_NEXT: r_y <= y_inc;
            default: ;
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_span_stb = r_out_stb;
    assign o_span     = r_out;

endmodule

FILE: rtl/trs_chk.sv
// port-level checker for the triangle span rasterizer, bound to the top level
module trs_chk
    import trs_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  start,
    input logic  busy,
    input logic  o_span_stb,
    input t_span o_span
);

    // an accepted triangle keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after triangle accept");

    // a word marked invalid closes its triangle and carries no span
    a_invalid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_stb && !o_span.span_valid) |->
            (o_span.last && (o_span.row == '0) && (o_span.x_start == '0)
             && (o_span.x_end == '0) && (o_span.span_color == '0)))
        else $error("invalid word with nonzero fields or without last");

    // the last word of a triangle shows with the block already idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_stb && o_span.last) |-> !busy)
        else $error("last word while still busy");

    // words before the last come while the triangle is still in work
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_span_stb && !o_span.last) |-> busy)
        else $error("non-last word while idle");

endmodule

bind triangle_span_rasterizer trs_chk u_trs_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_span_stb (o_span_stb),
    .o_span     (o_span)
);

FILE: verif/tb.sv
// testbench for the triangle span rasterizer: directed and random triangles against a span predictor
`timescale 1ns / 100ps

module tb;
    import trs_pkg::*;

    localparam int ROW_CYCLES   = 2 * DEF_COORD_BITS + 20;
    localparam int LIMIT_CYCLES = 3_000_000;

    // config indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    t_tri                  i_tri;
    logic                  busy;
    logic                  o_span_stb;
    t_span                 o_span;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // screen size as the block should hold it
    logic [SW_W-1:0] cfg_width;
    logic [SH_W-1:0] cfg_height;

    t_tri  tri_pending_q[$];
    t_span span_expect_q[$];

    logic        tri_taken;
    int          gap_left;
    int          burst_left;
    int          fail_count;
    int          tri_count;
    int          span_count;
    int          empty_count;
    int unsigned cycle_count;

    triangle_span_rasterizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_tri       (i_tri),
        .busy        (busy),
        .o_span_stb  (o_span_stb),
        .o_span      (o_span),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // x on an edge at row offset k, exact value truncated toward zero
    function automatic longint lerp_trunc(longint p, longint q, longint k, longint den);
        return (p * den + (q - p) * k) / den;
    endfunction

    // append a triangle word to the send queue
    function automatic void add_tri(input t_tri t);
        tri_pending_q.insert(tri_pending_q.size(), t);
    endfunction

    // append a span word to the expected queue
    function automatic void add_span(input t_span s);
        span_expect_q.insert(span_expect_q.size(), s);
    endfunction

    // spans of one triangle under the current screen size
    function automatic void predict_spans(input t_tri t);
        longint ax, ay, bx, by, cx, cy;
        longint h, w, total, ylo, yhi, upper, y, i, seg, xa, xb, tmp, xs, xe;
        bit     lower_half;
        int     n;
        t_span  s;
        ax = longint'($signed(t.ax));
        ay = longint'($signed(t.ay));
        bx = longint'($signed(t.bx));
        by = longint'($signed(t.by));
        cx = longint'($signed(t.cx));
        cy = longint'($signed(t.cy));
        h = longint'(cfg_height);
        if (h > DEF_MAX_ROWS) h = DEF_MAX_ROWS;
        w = longint'(cfg_width);
        if (w > DEF_MAX_COLS) w = DEF_MAX_COLS;
        total = cy - ay;
        n = 0;
        if (total > 0) begin
            ylo = (ay < 0) ? 0 : ay;
            yhi = (cy < h) ? cy : h;
            upper = by - ay;
            for (y = ylo; y < yhi && n < DEF_MAX_ROWS; y++) begin
                i = y - ay;
                lower_half = (i > upper) || (by == ay);
                seg = lower_half ? cy - by : upper;
                if (seg == 0) continue;
                xa = lerp_trunc(ax, cx, i, total);
                if (lower_half) xb = lerp_trunc(bx, cx, i - upper, seg);
                else xb = lerp_trunc(ax, bx, i, seg);
                if (xa > xb) begin
                    tmp = xa;
                    xa = xb;
                    xb = tmp;
                end
                xs = (xa < 0) ? 0 : xa;
                xe = (xb > w - 1) ? w - 1 : xb;
                if (xs > xe) continue;
                s.row        = y[ROW_W-1:0];
                s.x_start    = xs[COL_W-1:0];
                s.x_end      = xe[COL_W-1:0];
                s.span_color = t.fill_color;
                s.span_valid = 1'b1;
                s.last       = 1'b0;
                add_span(s);
                n++;
            end
        end
        if (n == 0) begin
            s = '0;
            s.last = 1'b1;
            add_span(s);
        end else begin
            span_expect_q[span_expect_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic t_tri make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                      int unsigned color);
        t_tri t;
        t.ax = 16'(ax);
        t.ay = 16'(ay);
        t.bx = 16'(bx);
        t.by = 16'(by);
        t.cx = 16'(cx);
        t.cy = 16'(cy);
        t.fill_color = 24'(color);
        return t;
    endfunction

    // mostly sorted triangles near the screen, some misordered, some raw noise
    function automatic t_tri random_tri();
        t_tri t;
        int   xr, yr, kind, tmp;
        int   xs[3];
        int   ys[3];
        xr = (cfg_width == 0) ? 64 : int'(cfg_width);
        yr = (cfg_height == 0) ? 32 : int'(cfg_height);
        if (yr > DEF_MAX_ROWS) yr = DEF_MAX_ROWS;
        kind = int'($urandom_range(0, 19));
        for (int k = 0; k < 3; k++) begin
            xs[k] = int'($urandom_range(0, xr + 48)) - 24;
            ys[k] = int'($urandom_range(0, yr + 16)) - 8;
        end
        if (kind < 15) begin
            // sort by y
            if (ys[0] > ys[1]) begin tmp = ys[0]; ys[0] = ys[1]; ys[1] = tmp; end
            if (ys[1] > ys[2]) begin tmp = ys[1]; ys[1] = ys[2]; ys[2] = tmp; end
            if (ys[0] > ys[1]) begin tmp = ys[0]; ys[0] = ys[1]; ys[1] = tmp; end
            // flat top or flat bottom now and then
            if (kind == 13) ys[1] = ys[0];
            if (kind == 14) ys[1] = ys[2];
        end
        if (kind >= 17) begin
            t = make_tri(int'($urandom()), int'($urandom()), int'($urandom()),
                         int'($urandom()), int'($urandom()), int'($urandom()), $urandom());
        end else begin
            t = make_tri(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom());
        end
        return t;
    endfunction

    // config write, taken while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH: begin
                cfg_width = val[SW_W-1:0];
            end
            REG_SCREEN_HEIGHT: begin
                cfg_height = val[SH_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off until every triangle is in and every span is out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (tri_pending_q.size() != 0 || span_expect_q.size() != 0 || busy);
        repeat (ROW_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(input logic [CFG_DATA_W-1:0] width_val,
                              input logic [CFG_DATA_W-1:0] height_val, input int count);
        write_reg(REG_SCREEN_WIDTH, width_val);
        write_reg(REG_SCREEN_HEIGHT, height_val);
        repeat (count) add_tri(random_tri());
        wait_drained();
    endtask

    // driver: presents the oldest pending triangle word in bursts with gaps
    always @(negedge i_clk) begin : drive
        logic holding;
        logic go;
        holding = start && !tri_taken;
        if (tri_taken) tri_pending_q.delete(0);
        if (holding) begin
            go = 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
            go = 1'b0;
        end else begin
            go = (tri_pending_q.size() != 0);
            if (go) begin
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = int'($urandom_range(1, 6));
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 80));
                end
            end
        end
        start <= go;
        if (go) i_tri <= tri_pending_q[0];
    end

    // monitor: checks span words, predicts on each accepted triangle
    always @(posedge i_clk) begin : watch
        t_span want;
        tri_taken = 1'b0;
        if (i_rst_n) begin
            if (o_span_stb) begin
                if (span_expect_q.size() == 0) begin
                    $error("span word with nothing expected: row %0d", o_span.row);
                    fail_count++;
                end else begin
                    want = span_expect_q.pop_front();
                    check_field("row", want.row, o_span.row);
                    check_field("x_start", want.x_start, o_span.x_start);
                    check_field("x_end", want.x_end, o_span.x_end);
                    check_field("span_color", want.span_color, o_span.span_color);
                    check_field("span_valid", want.span_valid, o_span.span_valid);
                    check_field("last", want.last, o_span.last);
                    if (o_span.span_valid) span_count++;
                    else empty_count++;
                end
            end
            if (start && !busy) begin
                tri_taken = 1'b1;
                predict_spans(i_tri);
                tri_count++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("triangle_span_rasterizer regression: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_tri       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SCREEN_WIDTH;
        i_cfg_data  = '0;
        cfg_width   = SW_RESET;
        cfg_height  = SH_RESET;
        tri_taken   = 1'b0;
        gap_left    = 0;
        burst_left  = 1;
        fail_count  = 0;
        tri_count   = 0;
        span_count  = 0;
        empty_count = 0;
        cycle_count = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed triangles at the reset screen size
        // plain triangle inside the screen
        add_tri(make_tri(10, 0, 30, 10, 5, 20, 24'h123456));
        // flat triangle, all y equal
        add_tri(make_tri(0, 5, 10, 5, 20, 5, 24'hABCDEF));
        // bottom above top
        add_tri(make_tri(0, 20, 10, 10, 5, 0, 24'h00FF00));
        // flat top: no upper half
        add_tri(make_tri(0, 0, 40, 0, 20, 30, 24'h0000FF));
        // flat bottom: no lower half
        add_tri(make_tri(20, 0, 0, 30, 40, 30, 24'hFF0000));
        // starts above the screen
        add_tri(make_tri(5, -30, 60, -5, 30, 10, 24'h111111));
        // runs past the bottom of the screen
        add_tri(make_tri(10, 40, 80, 120, 20, 200, 24'h222222));
        // entirely below the screen
        add_tri(make_tri(10, 100, 20, 110, 5, 120, 24'h333333));
        // entirely left of the screen
        add_tri(make_tri(-50, 5, -40, 10, -60, 15, 24'h444444));
        // entirely right of the screen
        add_tri(make_tri(300, 5, 400, 10, 350, 15, 24'h555555));
        // coordinate extremes
        add_tri(make_tri(-32768, -32768, 32767, 0, 32767, 32767, 24'hFFFFFF));
        add_tri(make_tri(32767, -32768, -32768, 32767, -32768, 32767, 24'h000000));
        // middle vertex above the top
        add_tri(make_tri(10, 10, 50, 0, 30, 30, 24'h666666));
        // middle vertex below the bottom
        add_tri(make_tri(10, 0, 50, 40, 30, 20, 24'h777777));
        // wider than the screen on both sides
        add_tri(make_tri(-100, 0, 500, 20, -100, 40, 24'h888888));
        // single row
        add_tri(make_tri(5, 3, 8, 3, 7, 4, 24'h999999));
        // top and middle above the screen
        add_tri(make_tri(-5, -20, 40, -3, 90, 25, 24'hAAAAAA));
        // clipped on the right edge only
        add_tri(make_tri(90, 2, 120, 8, 60, 14, 24'hBBBBBB));
        wait_drained();

        // random triangles under a range of screen sizes
        run_random(9'd256, 9'd64, 24);
        run_random(9'd1, 9'd1, 16);
        // oversized values, height with bits above its width
        run_random(9'h1FF, 9'h1FF, 20);
        run_random(9'd0, 9'd0, 10);
        write_reg(REG_SPARE_A, 9'h1FF);
        write_reg(REG_SPARE_B, 9'h000);
        run_random(9'd2, 9'd64, 16);
        run_random(9'd200, 9'd0, 6);
        run_random(9'd0, 9'd30, 6);
        repeat (2) run_random(9'($urandom_range(1, 300)), 9'($urandom_range(1, 70)), 20);
        run_random(9'd98, 9'd50, 8);

        if (span_expect_q.size() != 0) begin
            $error("%0d span words never arrived", span_expect_q.size());
            fail_count++;
        end
        $display("covered %0d triangles over several screen sizes in %0d cycles",
                 tri_count, cycle_count);
        $display("checked %0d spans and %0d no-span results", span_count, empty_count);
        if (fail_count == 0) begin
            $display("triangle_span_rasterizer regression: pass");
        end else begin
            $display("triangle_span_rasterizer regression: fail");
        end
        $finish;
    end

endmodule
